[sv/nearest_note_cents_meter_top_defines.svh]
// Assertion macros for the nearest note cents meter.
// Expect clk and rst_n in the scope of every use.
`ifndef NEAREST_NOTE_CENTS_METER_TOP_DEFINES_SVH
`define NEAREST_NOTE_CENTS_METER_TOP_DEFINES_SVH
`ifndef SYNTH
`define NNCM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("nncm assertion failed");
`define NNCM_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("nncm forbidden condition");
`else
`define NNCM_ASSERT(lbl, prop)
`define NNCM_NEVER(lbl, cond)
`endif
`endif

[sv/nncm_pkg.sv]
// Shared constants, types and functions of the nearest note cents meter.
// No dependencies.
`default_nettype none
package nncm_pkg;
  localparam int NOTE_COUNT = 96;
  localparam int IDX_W = 7;
  localparam int FREQ_W = 20;
  localparam int NV_W = 21;
  localparam int A4_W = 9;
  localparam int LOG_FRAC = 24;
  localparam int STEP_W = 5;
  localparam int BAR_LAMPS = 50;
  localparam int BAR_HALF = BAR_LAMPS / 2;
  localparam int FIFO_DEPTH = 2;
  localparam logic [A4_W-1:0] A4_RESET = 9'd440;
  localparam logic [15:0] RECIP5 = 16'd52429;

  typedef struct packed {
    logic              vld;
    logic [FREQ_W-1:0] freq;
  } nncm_item_t;

  function automatic logic [16:0] semitone_ratio(input logic [3:0] k);
    logic [16:0] r;
    case (k)
      4'd0:    r = 17'd38968;
      4'd1:    r = 17'd41285;
      4'd2:    r = 17'd43740;
      4'd3:    r = 17'd46341;
      4'd4:    r = 17'd49097;
      4'd5:    r = 17'd52016;
      4'd6:    r = 17'd55109;
      4'd7:    r = 17'd58386;
      4'd8:    r = 17'd61858;
      4'd9:    r = 17'd65536;
      4'd10:   r = 17'd69433;
      4'd11:   r = 17'd73562;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // a4 * ratio, right shift by (12 - octave), rounding half up
  function automatic logic [NV_W-1:0] note_value(input logic [A4_W-1:0] a4,
                                                 input logic [3:0] k,
                                                 input logic [2:0] oct);
    logic [25:0] p;
    logic [3:0]  sh;
    logic [25:0] t;
    logic [25:0] u;
    p = 26'(a4) * 26'(semitone_ratio(k));
    sh = 4'd11 - 4'(oct);
    t = p >> sh;
    u = (t + 26'd1) >> 1;
    return u[NV_W-1:0];
  endfunction

  function automatic logic [STEP_W-1:0] msb_pos(input logic [NV_W-1:0] x);
    logic [STEP_W-1:0] pos;
    pos = '0;
    for (int b = 0; b < NV_W; b++) begin
      if (x[b]) pos = STEP_W'(b);
    end
    return pos;
  endfunction
endpackage
`default_nettype wire

[sv/nearest_note_cents_meter_top.sv]
// Top level of the nearest note cents meter: A4 register, front queue, back end.
// Depends on nncm_pkg, nncm_front and nncm_back.
// In the back end a pitch transaction walks up to 96 notes, one note per cycle
// through a single 9x17 multiplier; the log step then runs 24 squaring steps for
// both operands at once. A two-entry queue takes input while the back end works,
// and a zero pitch is accepted and gives no result.
`default_nettype none
module nearest_note_cents_meter_top import nncm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [A4_W-1:0]   cfg_reference_a4_hz,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [FREQ_W-1:0] in_frequency_q8,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [IDX_W-1:0]       out_note_index,
  output logic [FREQ_W-1:0]      out_note_freq_q8,
  output logic signed [15:0]     out_cents_tenths,
  output logic                   out_cents_saturated,
  output logic signed [5:0]      out_bar_offset,
  output logic [BAR_LAMPS-1:0]   out_bar_mask
);
  logic [A4_W-1:0] a4_r;
  nncm_item_t      item;
  logic            item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) a4_r <= A4_RESET;
    else if (cfg_we) a4_r <= cfg_reference_a4_hz;
  end

  nncm_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_frequency_q8, .item, .item_take
  );

  nncm_back u_back (
    .clk, .rst_n, .a4(a4_r), .item, .item_take, .out_empty, .out_pop,
    .out_note_index, .out_note_freq_q8, .out_cents_tenths,
    .out_cents_saturated, .out_bar_offset, .out_bar_mask
  );
endmodule
`default_nettype wire

[sv/nncm_front.sv]
// Input side: accepts pitch transactions, drops zero pitch, queues the rest.
// Depends on nncm_pkg.
`default_nettype none
`include "nearest_note_cents_meter_top_defines.svh"
module nncm_front import nncm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [FREQ_W-1:0] in_frequency_q8,
  output nncm_item_t             item,
  input  wire logic              item_take
);
  logic [FREQ_W-1:0] mem_r [FIFO_DEPTH];
  logic              wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              wr, rd;

  assign in_full = (cnt_r == 2'(FIFO_DEPTH));
  assign wr = in_push && !in_full && (in_frequency_q8 != '0);
  assign rd = item_take && (cnt_r != 2'd0);
  assign item.vld = (cnt_r != 2'd0);
  assign item.freq = mem_r[rp_r];

  always_comb begin
    wp_nxt = wr ? !wp_r : wp_r;
    rp_nxt = rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= in_frequency_q8;
  end

  `NNCM_NEVER(a_fifo_over, cnt_r > 2'(FIFO_DEPTH))
endmodule
`default_nettype wire

[sv/nncm_back.sv]
// Back end: note walk, dual iterative log2, cents and tuning bar.
// Depends on nncm_pkg.
`default_nettype none
`include "nearest_note_cents_meter_top_defines.svh"
module nncm_back import nncm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [A4_W-1:0]   a4,
  input  wire nncm_item_t        item,
  output logic                   item_take,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [IDX_W-1:0]       out_note_index,
  output logic [FREQ_W-1:0]      out_note_freq_q8,
  output logic signed [15:0]     out_cents_tenths,
  output logic                   out_cents_saturated,
  output logic signed [5:0]      out_bar_offset,
  output logic [BAR_LAMPS-1:0]   out_bar_mask
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_WALK  = 8'b0000_0100,
    S_LOGI  = 8'b0000_1000,
    S_LOG   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_CENTS = 8'b0100_0000,
    S_BAR   = 8'b1000_0000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [FREQ_W-1:0]      fs_r;
  logic [IDX_W-1:0]       idx_r, j_r;
  logic [3:0]             k_r;
  logic [2:0]             oct_r;
  logic signed [22:0]     best_r, d;
  logic [NV_W-1:0]        nv, nfb_r;
  logic [30:0]            mf_r, mn_r;
  logic [STEP_W-1:0]      ef_r, en_r, step_r;
  logic [LOG_FRAC-1:0]    ff_r, fn_r;
  logic [61:0]            sqf, sqn;
  logic [31:0]            tf, tn;
  logic [STEP_W-1:0]      ef, en;
  logic signed [29:0]     diff;
  logic signed [44:0]     prod_r;
  logic [43:0]            pmag;
  logic [20:0]            rnd;
  logic signed [15:0]     cents_r;
  logic                   sat_r;
  logic [16:0]            cmag, cx;
  logic [30:0]            qprod;
  logic [12:0]            q;
  logic [4:0]             qc;
  logic signed [5:0]      bar;
  logic [BAR_LAMPS-1:0]   mask;
  logic                   out_vld_r, take, walk_last;

  function automatic logic [22:0] mag23(input logic signed [22:0] v);
    return v[22] ? 23'(-v) : 23'(v);
  endfunction

  assign nv = note_value(a4, k_r, oct_r);
  assign d = $signed({3'b000, fs_r}) - $signed({2'b00, nv});
  assign take = (mag23(d) <= mag23(best_r));
  assign walk_last = (idx_r == IDX_W'(NOTE_COUNT - 1));
  assign item_take = state_r[0];
  assign ef = msb_pos({1'b0, fs_r});
  assign en = msb_pos(nfb_r);
  assign sqf = 62'(mf_r) * 62'(mf_r);
  assign sqn = 62'(mn_r) * 62'(mn_r);
  assign tf = sqf[61:30];
  assign tn = sqn[61:30];
  assign diff = $signed({1'b0, ef_r, ff_r}) - $signed({1'b0, en_r, fn_r});
  assign pmag = prod_r[44] ? 44'(-prod_r) : 44'(prod_r);
  assign rnd = 21'((pmag + 44'(1 << (LOG_FRAC - 1))) >> LOG_FRAC);
  assign cmag = cents_r[15] ? 17'(-$signed({cents_r[15], cents_r})) : 17'(cents_r);
  assign cx = cmag + 17'd10;
  assign qprod = 31'(cx[16:2]) * 31'(RECIP5);
  assign q = qprod[30:18];
  assign qc = (q > 13'(BAR_HALF)) ? 5'(BAR_HALF) : q[4:0];
  assign bar = cents_r[15] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

  always_comb begin
    mask = '0;
    for (int t = 0; t < BAR_LAMPS; t++) begin
      if (qc == 5'd0) mask[t] = (t == BAR_HALF);
      else if (!cents_r[15]) mask[t] = (t > BAR_HALF) && (t <= BAR_HALF + int'(qc));
      else mask[t] = (t >= BAR_HALF - int'(qc)) && (t < BAR_HALF);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (item.vld) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_WALK;
      S_WALK:  if (!take || walk_last) state_nxt = S_LOGI;
      S_LOGI:  state_nxt = S_LOG;
      S_LOG:   if (step_r == '0) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CENTS;
      S_CENTS: state_nxt = S_BAR;
      S_BAR:   if (!out_vld_r || out_pop) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_BAR && (!out_vld_r || out_pop)) out_vld_r <= 1'b1;
      else if (out_pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        fs_r <= item.freq;
        idx_r <= '0;
        k_r <= '0;
        oct_r <= '0;
      end
      S_INIT: begin
        best_r <= d + 23'sd2560;
        j_r <= '0;
        nfb_r <= nv;
      end
      S_WALK: begin
        if (take) begin
          best_r <= d;
          j_r <= idx_r;
          nfb_r <= nv;
          idx_r <= idx_r + 1'b1;
          if (k_r == 4'd11) begin
            k_r <= '0;
            oct_r <= oct_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
      end
      S_LOGI: begin
        ef_r <= ef;
        en_r <= en;
        mf_r <= 31'(31'(fs_r) << (5'd30 - ef));
        mn_r <= 31'(31'(nfb_r) << (5'd30 - en));
        ff_r <= '0;
        fn_r <= '0;
        step_r <= STEP_W'(LOG_FRAC - 1);
      end
      S_LOG: begin
        mf_r <= tf[31] ? tf[31:1] : tf[30:0];
        mn_r <= tn[31] ? tn[31:1] : tn[30:0];
        ff_r[step_r] <= tf[31];
        fn_r[step_r] <= tn[31];
        step_r <= step_r - 1'b1;
      end
      S_MUL: prod_r <= 45'(diff) * 45'sd12000;
      S_CENTS: begin
        if (nfb_r == '0) begin
          cents_r <= 16'sd32767;
          sat_r <= 1'b1;
        end else if (!prod_r[44]) begin
          cents_r <= (rnd >= 21'd32767) ? 16'sd32767 : $signed(rnd[15:0]);
          sat_r <= (rnd >= 21'd32767);
        end else begin
          cents_r <= (rnd >= 21'd32768) ? -16'sd32768 : -$signed(rnd[15:0]);
          sat_r <= (rnd >= 21'd32768);
        end
      end
      S_BAR: begin
        if (!out_vld_r || out_pop) begin
          out_note_index <= j_r;
          out_note_freq_q8 <= nfb_r[NV_W-1] ? '1 : nfb_r[FREQ_W-1:0];
          out_cents_tenths <= cents_r;
          out_cents_saturated <= sat_r;
          out_bar_offset <= bar;
          out_bar_mask <= mask;
        end
      end
      default: ;
    endcase
  end

  assign out_empty = !out_vld_r;

  `NNCM_ASSERT(a_bar_range, out_vld_r |-> (out_bar_offset <= 6'sd25 && out_bar_offset >= -6'sd25))
  `NNCM_ASSERT(a_note_range, out_vld_r |-> (out_note_index < IDX_W'(NOTE_COUNT)))
  `NNCM_ASSERT(a_sat_limit, (out_vld_r && out_cents_saturated) |-> (out_cents_tenths == 16'sd32767 || out_cents_tenths == -16'sd32768))
  `NNCM_ASSERT(a_mask_lit, out_vld_r |-> (out_bar_mask != '0))
endmodule
`default_nettype wire

[tb/nearest_note_cents_meter_top_test.sv]
// Self-checking testbench for nearest_note_cents_meter_top: pitch transactions against an
// in-bench nearest-note/cents predictor, across several A4 settings and idling phases.
// Depends on nncm_pkg and nearest_note_cents_meter_top.
module nearest_note_cents_meter_top_test;
  import nncm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;
  localparam longint unsigned SEMIS [12] = '{38968, 41285, 43740, 46341, 49097, 52016,
                                             55109, 58386, 61858, 65536, 69433, 73562};

  typedef struct {
    logic [6:0]         idx;
    logic [19:0]        nf;
    logic signed [15:0] cents;
    logic               sat;
    logic signed [5:0]  bar;
    logic [49:0]        mask;
  } reading_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [A4_W-1:0] cfg_a4;
  logic in_push;
  logic in_full;
  logic [FREQ_W-1:0] in_freq;
  logic out_empty;
  logic out_pop;
  logic [IDX_W-1:0] out_idx;
  logic [FREQ_W-1:0] out_nf;
  logic signed [15:0] out_cents;
  logic out_sat;
  logic signed [5:0] out_bar;
  logic [BAR_LAMPS-1:0] out_mask;

  nearest_note_cents_meter_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_reference_a4_hz(cfg_a4),
    .in_push(in_push), .in_full(in_full), .in_frequency_q8(in_freq),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_note_index(out_idx), .out_note_freq_q8(out_nf),
    .out_cents_tenths(out_cents), .out_cents_saturated(out_sat),
    .out_bar_offset(out_bar), .out_bar_mask(out_mask)
  );

  logic [8:0] a4_hz;
  logic [19:0] pending_pitches[$];
  reading_t expected_readings[$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int readings_seen;
  int pitches_sent;
  int quiet_cycles;
  int hold_left;
  bit hold_tog;
  bit hold_seen;

  function automatic longint unsigned note_hz_q8(input logic [8:0] a4, input int idx);
    int oct;
    int sh;
    longint unsigned p;
    oct = idx / 12;
    p = longint'(a4) * SEMIS[idx % 12];
    sh = 12 - oct;
    return (p + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic longint log2_q24(input longint unsigned x);
    int e;
    longint unsigned m;
    longint r;
    e = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e <= 30) m = x << (30 - e);
    else m = x >> (e - 30);
    r = longint'(e) << LOG_FRAC;
    for (int b = LOG_FRAC - 1; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r | (longint'(1) << b);
      end
    end
    return r;
  endfunction

  function automatic reading_t tune_reading(input logic [8:0] a4, input logic [19:0] f);
    reading_t rd;
    longint fs, best, d, cents, mag, bar, prod, lo, hi;
    longint unsigned nf;
    int j;
    bit sat;
    fs = longint'(f);
    best = fs - (longint'(note_hz_q8(a4, 0)) - (longint'(10) << 8));
    j = 0;
    for (int i = 0; i < NOTE_COUNT; i++) begin
      d = fs - longint'(note_hz_q8(a4, i));
      if ((d < 0 ? -d : d) <= (best < 0 ? -best : best)) begin
        best = d;
        j = i;
      end else break;
    end
    nf = note_hz_q8(a4, j);
    sat = 0;
    if (nf == 0) begin
      cents = 32767;
      sat = 1;
    end else begin
      prod = 12000 * (log2_q24(longint'(f)) - log2_q24(nf));
      mag = prod < 0 ? -prod : prod;
      mag = (mag + (longint'(1) << (LOG_FRAC - 1))) >> LOG_FRAC;
      cents = prod < 0 ? -mag : mag;
      if (cents >= 32767) begin
        cents = 32767;
        sat = 1;
      end else if (cents <= -32768) begin
        cents = -32768;
        sat = 1;
      end
    end
    mag = cents < 0 ? -cents : cents;
    mag = (mag + 10) / 20;
    bar = cents < 0 ? -mag : mag;
    if (bar > BAR_HALF) bar = BAR_HALF;
    if (bar < -BAR_HALF) bar = -BAR_HALF;
    if (bar > 0) begin
      lo = BAR_HALF + 1;
      hi = BAR_HALF + bar;
    end else if (bar < 0) begin
      lo = BAR_HALF + bar;
      hi = BAR_HALF - 1;
    end else begin
      lo = BAR_HALF;
      hi = BAR_HALF;
    end
    rd.mask = '0;
    for (longint t = lo; t <= hi; t++) begin
      if (t >= 0 && t < BAR_LAMPS) rd.mask[t] = 1'b1;
    end
    rd.idx = 7'(j);
    rd.nf = nf > 64'hFFFFF ? 20'hFFFFF : 20'(nf);
    rd.cents = 16'(cents);
    rd.sat = sat;
    rd.bar = 6'(bar);
    return rd;
  endfunction

  function automatic logic [19:0] clip_pitch(input longint v);
    if (v < 1) return 20'd1;
    if (v > 64'hFFFFF) return 20'hFFFFF;
    return 20'(v);
  endfunction

  function automatic logic [19:0] random_pitch(input logic [8:0] a4);
    int sel;
    int sh;
    longint nv;
    longint w;
    sel = $urandom_range(99);
    if (sel < 60) begin
      nv = longint'(note_hz_q8(a4, $urandom_range(NOTE_COUNT - 1)));
      w = nv / 16 + 2;
      return clip_pitch(nv + longint'($urandom_range(2 * w)) - w);
    end
    if (sel < 80) return 20'($urandom);
    if (sel < 97) begin
      sh = $urandom_range(19);
      return 20'($urandom) & ((20'd2 << sh) - 20'd1);
    end
    return 20'd0;
  endfunction

  task automatic write_a4(input logic [8:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_a4 <= v;
    a4_hz = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] a4, input int s_pct, input int r_pct,
                           input int count, input bit hold);
    write_a4(a4);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (hold) hold_tog = ~hold_tog;
    for (int n = 0; n < count; n++) pending_pitches.push_back(random_pitch(a4));
    while (pending_pitches.size() != 0 || expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    longint nv;
    longint nv2;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_a4 = '0;
    a4_hz = A4_RESET;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches = 0;
    readings_seen = 0;
    pitches_sent = 0;
    hold_tog = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, zero pitch, exact notes, ties, below the lowest note, single bits
    pending_pitches.push_back(20'd0);
    pending_pitches.push_back(20'd1);
    pending_pitches.push_back(20'hFFFFF);
    pending_pitches.push_back(20'd440 << 8);
    pending_pitches.push_back(20'(note_hz_q8(A4_RESET, 0)));
    pending_pitches.push_back(20'(note_hz_q8(A4_RESET, NOTE_COUNT - 1)));
    pending_pitches.push_back(20'd1000);
    for (int i = 10; i < 90; i += 20) begin
      nv = longint'(note_hz_q8(A4_RESET, i));
      nv2 = longint'(note_hz_q8(A4_RESET, i + 1));
      pending_pitches.push_back(20'((nv + nv2) / 2));
      pending_pitches.push_back(20'((nv + nv2 + 1) / 2));
      pending_pitches.push_back(20'(nv + nv / 40));
    end
    for (int b = 0; b < 20; b += 3) pending_pitches.push_back(20'd1 << b);
    while (pending_pitches.size() != 0 || expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    run_phase(9'd440, 0, 0, 60, 1'b0);
    run_phase(9'd400, 51, 0, 85, 1'b0);
    run_phase(9'd480, 0, 51, 85, 1'b1);
    run_phase(9'd0, 31, 31, 30, 1'b0);
    run_phase(9'd511, 0, 0, 60, 1'b0);
    run_phase(9'(400 + $urandom_range(80)), 31, 31, 150, 1'b0);

    $display("Covered %0d pitch transactions and %0d readings over six A4 settings,",
             pitches_sent, readings_seen);
    $display("with sender and receiver idling phases and one long receiver hold-off.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Driver
  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      in_push <= 1'b0;
      in_freq <= '0;
    end else begin
      if (in_push && !in_full) begin
        void'(pending_pitches.pop_front());
        pitches_sent++;
        if (in_freq != 0) expected_readings.push_back(tune_reading(a4_hz, in_freq));
      end
      offer = pending_pitches.size() != 0 && $urandom_range(99) >= send_idle_pct;
      in_push <= offer;
      in_freq <= offer ? pending_pitches[0] : 20'($urandom);
    end
  end

  // Monitor
  always @(posedge clk) begin
    reading_t exp_rd;
    if (!rst_n) begin
      out_pop <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected reading: note %0d", out_idx);
        end else begin
          exp_rd = expected_readings.pop_front();
          if (out_idx !== exp_rd.idx || out_nf !== exp_rd.nf || out_cents !== exp_rd.cents ||
              out_sat !== exp_rd.sat || out_bar !== exp_rd.bar || out_mask !== exp_rd.mask) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch exp: note %0d nf %0h cents %0d sat %0b bar %0d mask %0h",
                       exp_rd.idx, exp_rd.nf, exp_rd.cents, exp_rd.sat, exp_rd.bar,
                       exp_rd.mask);
              $display("         got: note %0d nf %0h cents %0d sat %0b bar %0d mask %0h",
                       out_idx, out_nf, out_cents, out_sat, out_bar, out_mask);
            end
          end
        end
      end
      if (hold_tog != hold_seen) begin
        hold_seen <= hold_tog;
        hold_left <= HOLD_CYCLES;
        out_pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= $urandom_range(99) >= recv_idle_pct;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;
endmodule
